// ===== sv/c8alu_pkg.sv =====
// c8alu_pkg: operation codes, flag positions, daa constants and beat types
// for the 8-bit cpu flag alu. no dependencies.
package c8alu_pkg;

  typedef enum logic [3:0] {
    OP_INC8  = 4'd0,
    OP_DEC8  = 4'd1,
    OP_RLC   = 4'd2,
    OP_RRC   = 4'd3,
    OP_RL    = 4'd4,
    OP_RR    = 4'd5,
    OP_ADD16 = 4'd6,
    OP_DAA   = 4'd7,
    OP_INC16 = 4'd8,
    OP_DEC16 = 4'd9
  } op_t;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [8:0] DAA_HI_LIMIT = 9'h09F;
  localparam logic [3:0] NIBBLE_LIMIT = 4'd9;
  localparam int         ADD16_HALF_BIT = 12;

  typedef struct packed {
    op_t         op;
    logic [7:0]  value8;
    logic [15:0] pair16;
    logic [15:0] addend16;
    logic [3:0]  flags_in;
    logic        rotate_on_a;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } rsp_t;

endpackage

// ===== sv/cpu8_alu_inc_rot_daa.sv =====
// cpu8_alu_inc_rot_daa: three stage flag alu (input register, arithmetic, flag select).
// depends on c8alu_pkg for op codes, flag positions and beat types.
//
// Each accepted request beat passes the input register, the arithmetic register and the
// output register before its response beat; one beat can enter each cycle unless
// req_stall is high. The pipeline has an input register, an arithmetic stage (8/16-bit
// adders, rotates, first daa correction) and an output register that holds the second
// daa correction and the flag logic. Empty stages close up under a response stall, so
// req_stall rises only when all three stages hold a beat while rsp_stall is high. The
// block has no state beyond the pipeline: flags come in with each request.
module cpu8_alu_inc_rot_daa
  import c8alu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic        a_valid;
  req_t        a_req;
  logic        b_valid;
  op_t         b_op;
  logic [3:0]  b_flags;
  logic        b_rot_a;
  logic [16:0] b_res;
  logic        b_half;

  logic        en_a, en_b, en_c;
  logic [16:0] b_res_next;
  logic        b_half_next;
  rsp_t        rsp_next;

  assign en_c      = !(rsp_valid && rsp_stall);
  assign en_b      = !b_valid || en_c;
  assign en_a      = !a_valid || en_b;
  assign req_stall = !en_a;

  // stage a: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= req_valid;
    end
    if (en_a && req_valid) begin
      a_req <= req;
    end
  end

  // stage b: adders, rotates and first daa correction
  always_comb begin
    logic [7:0]  v;
    logic        cin;
    logic [16:0] sum;
    v           = a_req.value8;
    cin         = a_req.flags_in[FLAG_C];
    sum         = {1'b0, a_req.pair16} + {1'b0, a_req.addend16};
    b_half_next = 1'b0;
    case (a_req.op)
      OP_INC8:  b_res_next = {9'd0, v + 8'd1};
      OP_DEC8:  b_res_next = {9'd0, v - 8'd1};
      OP_RLC:   b_res_next = {8'd0, v[7], v[6:0], v[7]};
      OP_RRC:   b_res_next = {8'd0, v[0], v[0], v[7:1]};
      OP_RL:    b_res_next = {8'd0, v[7], v[6:0], cin};
      OP_RR:    b_res_next = {8'd0, v[0], cin, v[7:1]};
      OP_ADD16: begin
        b_res_next  = sum;
        b_half_next = a_req.pair16[ADD16_HALF_BIT] ^ a_req.addend16[ADD16_HALF_BIT]
                      ^ sum[ADD16_HALF_BIT];
      end
      OP_DAA: begin
        if (!a_req.flags_in[FLAG_N]) begin
          if (a_req.flags_in[FLAG_H] || (v[3:0] > NIBBLE_LIMIT)) begin
            b_res_next = {8'd0, {1'b0, v} + {1'b0, DAA_LO_ADJ}};
          end else begin
            b_res_next = {9'd0, v};
          end
        end else begin
          if (a_req.flags_in[FLAG_H]) begin
            b_res_next = {9'd0, v - DAA_LO_ADJ};
          end else begin
            b_res_next = {9'd0, v};
          end
        end
      end
      OP_INC16: b_res_next = {1'b0, a_req.pair16 + 16'd1};
      OP_DEC16: b_res_next = {1'b0, a_req.pair16 - 16'd1};
      default:  b_res_next = 17'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
    if (en_b && a_valid) begin
      b_op    <= a_req.op;
      b_flags <= a_req.flags_in;
      b_rot_a <= a_req.rotate_on_a;
      b_res   <= b_res_next;
      b_half  <= b_half_next;
    end
  end

  // stage c: daa high correction and flags
  always_comb begin
    logic [7:0] r8;
    logic [8:0] a2;
    logic       cin;
    r8       = b_res[7:0];
    cin      = b_flags[FLAG_C];
    a2       = b_res[8:0];
    rsp_next = '0;
    case (b_op)
      OP_INC8: begin
        rsp_next.result            = {8'd0, r8};
        rsp_next.flags_out[FLAG_Z] = (r8 == 8'd0);
        rsp_next.flags_out[FLAG_H] = (r8[3:0] == 4'h0);
        rsp_next.flags_out[FLAG_C] = cin;
      end
      OP_DEC8: begin
        rsp_next.result            = {8'd0, r8};
        rsp_next.flags_out[FLAG_Z] = (r8 == 8'd0);
        rsp_next.flags_out[FLAG_N] = 1'b1;
        rsp_next.flags_out[FLAG_H] = (r8[3:0] == 4'hF);
        rsp_next.flags_out[FLAG_C] = cin;
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR: begin
        rsp_next.result            = {8'd0, r8};
        rsp_next.flags_out[FLAG_Z] = !b_rot_a && (r8 == 8'd0);
        rsp_next.flags_out[FLAG_C] = b_res[8];
      end
      OP_ADD16: begin
        rsp_next.result            = b_res[15:0];
        rsp_next.flags_out[FLAG_Z] = b_flags[FLAG_Z];
        rsp_next.flags_out[FLAG_H] = b_half;
        rsp_next.flags_out[FLAG_C] = b_res[16];
      end
      OP_DAA: begin
        if (!b_flags[FLAG_N]) begin
          if (cin || (b_res[8:0] > DAA_HI_LIMIT)) begin
            a2 = b_res[8:0] + {1'b0, DAA_HI_ADJ};
          end
          rsp_next.flags_out[FLAG_C] = cin | a2[8];
        end else begin
          if (cin) begin
            a2 = {1'b0, r8 - DAA_HI_ADJ};
          end
          rsp_next.flags_out[FLAG_C] = cin;
        end
        rsp_next.result            = {8'd0, a2[7:0]};
        rsp_next.flags_out[FLAG_Z] = (a2[7:0] == 8'd0);
        rsp_next.flags_out[FLAG_N] = b_flags[FLAG_N];
      end
      OP_INC16, OP_DEC16: begin
        rsp_next.result    = b_res[15:0];
        rsp_next.flags_out = b_flags;
      end
      default: begin
        rsp_next.result    = 16'd0;
        rsp_next.flags_out = b_flags;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en_c) begin
      rsp_valid <= b_valid;
    end
    if (en_c && b_valid) begin
      rsp <= rsp_next;
    end
  end

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (a_valid && b_valid && rsp_valid && rsp_stall))
    else $error("request stalled with a free stage");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> (!a_valid && !b_valid && !rsp_valid))
    else $error("pipeline not empty after reset");

  a_hold_a : assert property (@(posedge clk) disable iff (rst)
    (a_valid && !en_b) |=> (a_valid && $stable(a_req)))
    else $error("input stage lost a beat under stall");

  a_hold_b : assert property (@(posedge clk) disable iff (rst)
    (b_valid && !en_c) |=> (b_valid && $stable(b_res) && $stable(b_op) && $stable(b_flags)))
    else $error("arithmetic stage lost a beat under stall");

endmodule
